### rtl/ktbl_pkg.sv
// ----------------------------------------------------------------------------
// ktbl_pkg
// shared types and constants of the keyed token bucket limiter
// ----------------------------------------------------------------------------
package ktbl_pkg;

    localparam int CAP_W           = 16;
    localparam int PERIOD_W        = 20;
    localparam int TIME_W          = 48;
    localparam int IDX_W           = 8;
    localparam int CFG_W           = 20;
    localparam int DEF_NUM_BUCKETS = 256;
    localparam int DEF_FRAC_BITS   = 16;

    typedef enum logic [0:0] {
        REG_CAPACITY = 1'b0,
        REG_PERIOD   = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [IDX_W-1:0]  bucket_index;
        logic [TIME_W-1:0] timestamp;
    } lim_req_t;

    typedef struct packed {
        logic                allowed;
        logic [CAP_W-1:0]    tokens_left;
        logic [PERIOD_W-1:0] retry_after;
    } lim_rsp_t;

    typedef struct packed {
        logic clr_wr;
        logic load;
        logic rd;
        logic eval;
        logic div_start;
        logic div_wait;
        logic fill_add;
        logic deficit;
        logic wait_take;
        logic commit;
    } lim_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic need_div;
        logic has_token;
        logic div_done;
    } lim_sts_t;

endpackage

### rtl/ktbl_ram.sv
// ----------------------------------------------------------------------------
// ktbl_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module ktbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/ktbl_div.sv
// ----------------------------------------------------------------------------
// ktbl_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ktbl_div #(
    parameter int DVD_W = 52,
    parameter int DVS_W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = CNT_W'(DVD_W);
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/ktbl_dp.sv
// ----------------------------------------------------------------------------
// ktbl_dp
// datapath: configuration, bucket table, refill and retry arithmetic
// ----------------------------------------------------------------------------
module ktbl_dp #(
    parameter int NUM_BUCKETS = 256,
    parameter int FRAC_BITS   = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ktbl_pkg::lim_cmd_t   cmd,
    output ktbl_pkg::lim_sts_t   sts,
    input  ktbl_pkg::lim_req_t   req,
    output logic                 done,
    output ktbl_pkg::lim_rsp_t   rsp,
    input  logic                 cfg_we,
    input  ktbl_pkg::cfg_reg_t   cfg_index,
    input  logic [ktbl_pkg::CFG_W-1:0] cfg_data
);

    import ktbl_pkg::*;

    localparam int AW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int TOK_W = CAP_W + FRAC_BITS;
    localparam int DVD_W = CAP_W + PERIOD_W + FRAC_BITS;
    localparam int ENT_W = 1 + TOK_W + TIME_W;
    localparam int MOD_W = IDX_W + 17;

    function automatic logic [IDX_W-1:0] bucket_mod(input logic [IDX_W-1:0] v);
        logic [MOD_W-1:0] r;
        logic [MOD_W-1:0] m;
        r = MOD_W'(v);
        for (int k = IDX_W - 1; k >= 0; k--)
        begin
            m = MOD_W'(NUM_BUCKETS) << k;
            if (r >= m)
            begin
                r = r - m;
            end
        end
        return r[IDX_W-1:0];
    endfunction

    logic [CAP_W-1:0]       cap_reg;
    logic [PERIOD_W-1:0]    per_reg;
    logic [AW-1:0]          clr_reg;
    logic [AW-1:0]          idx_reg;
    logic [TIME_W-1:0]      now_reg;
    logic [TIME_W-1:0]      last_reg;
    logic [TOK_W-1:0]       tok_reg;
    logic [PERIOD_W-1:0]    elap_reg;
    logic [FRAC_BITS:0]     def_reg;
    logic [PERIOD_W-1:0]    wait_reg;
    logic                   need_reg;
    logic                   done_reg;
    lim_rsp_t               rsp_reg;

    logic [CAP_W-1:0]       cap_eff;
    logic [PERIOD_W-1:0]    per_eff;
    logic [TOK_W-1:0]       cap_fixed;
    logic [TOK_W-1:0]       one_fixed;
    logic [ENT_W-1:0]       rdata;
    logic [ENT_W-1:0]       wdata;
    logic [AW-1:0]          waddr;
    logic                   we;
    logic                   st_valid;
    logic [TOK_W-1:0]       base_tok;
    logic [TIME_W-1:0]      base_time;
    logic                   later;
    logic [TIME_W-1:0]      elapsed;
    logic                   full;
    logic                   has_token;
    logic [TOK_W-1:0]       tok_after;
    logic [CAP_W+PERIOD_W-1:0]    fprod;
    logic [FRAC_BITS+PERIOD_W:0]  wprod;
    logic [DVD_W-1:0]       dvd;
    logic [TOK_W-1:0]       dvs;
    logic                   div_done;
    logic [DVD_W-1:0]       quo;
    logic [TOK_W:0]         fill_sum;

    assign cap_eff   = (cap_reg == '0) ? CAP_W'(1) : cap_reg;
    assign per_eff   = (per_reg == '0) ? PERIOD_W'(1) : per_reg;
    assign cap_fixed = {cap_eff, {FRAC_BITS{1'b0}}};
    assign one_fixed = TOK_W'(1) << FRAC_BITS;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_W'(1);
            per_reg <= PERIOD_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CAPACITY: cap_reg <= cfg_data[CAP_W-1:0];
                REG_PERIOD:   per_reg <= cfg_data[PERIOD_W-1:0];
                default:      ;
            endcase
        end
    end

    // bucket entry: valid, tokens, last refill time
    assign st_valid  = rdata[ENT_W-1];
    assign base_tok  = st_valid ? rdata[TIME_W +: TOK_W] : cap_fixed;
    assign base_time = st_valid ? rdata[TIME_W-1:0] : now_reg;
    assign later     = now_reg > base_time;
    assign elapsed   = now_reg - base_time;
    assign full      = later && (elapsed >= TIME_W'(per_eff));

    assign has_token = tok_reg >= one_fixed;
    assign tok_after = has_token ? (tok_reg - one_fixed) : tok_reg;

    assign fprod = elap_reg * cap_eff;
    assign wprod = def_reg * per_eff;
    assign dvd   = cmd.div_wait
                 ? (DVD_W'(wprod) + DVD_W'(cap_fixed) - DVD_W'(1))
                 : {fprod, {FRAC_BITS{1'b0}}};
    assign dvs   = cmd.div_wait ? cap_fixed : TOK_W'(per_eff);

    assign fill_sum = {1'b0, tok_reg} + {1'b0, quo[TOK_W-1:0]};

    assign we    = cmd.clr_wr || cmd.commit;
    assign waddr = cmd.clr_wr ? clr_reg : idx_reg;
    assign wdata = cmd.clr_wr ? '0 : {1'b1, tok_after, last_reg};

    ktbl_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_BUCKETS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    ktbl_div #(
        .DVD_W (DVD_W),
        .DVS_W (TOK_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .done     (div_done),
        .quotient (quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_wr)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            done_reg <= cmd.commit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg <= AW'(bucket_mod(req.bucket_index));
            now_reg <= req.timestamp;
        end
        if (cmd.eval)
        begin
            tok_reg  <= full ? cap_fixed : base_tok;
            last_reg <= later ? now_reg : base_time;
            need_reg <= later && !full;
            elap_reg <= elapsed[PERIOD_W-1:0];
        end
        if (cmd.fill_add)
        begin
            tok_reg <= (fill_sum > {1'b0, cap_fixed}) ? cap_fixed : fill_sum[TOK_W-1:0];
        end
        if (cmd.deficit)
        begin
            def_reg <= (FRAC_BITS+1)'(one_fixed - tok_reg);
        end
        if (cmd.wait_take)
        begin
            wait_reg <= quo[PERIOD_W-1:0];
        end
        if (cmd.commit)
        begin
            rsp_reg.allowed     <= has_token;
            rsp_reg.tokens_left <= has_token ? tok_after[FRAC_BITS +: CAP_W] : '0;
            rsp_reg.retry_after <= has_token ? '0 : wait_reg;
        end
    end

    assign sts.clr_last  = (clr_reg == AW'(NUM_BUCKETS - 1));
    assign sts.need_div  = need_reg;
    assign sts.has_token = has_token;
    assign sts.div_done  = div_done;

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

### rtl/ktbl_ctrl.sv
// ----------------------------------------------------------------------------
// ktbl_ctrl
// request sequencer: table clear, lookup, refill, retry, write back
// ----------------------------------------------------------------------------
module ktbl_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ktbl_pkg::lim_sts_t sts,
    output ktbl_pkg::lim_cmd_t cmd
);

    import ktbl_pkg::*;

    typedef enum logic [9:0] {
        ST_CLEAR     = 10'b00_0000_0001,
        ST_IDLE      = 10'b00_0000_0010,
        ST_READ      = 10'b00_0000_0100,
        ST_EVAL      = 10'b00_0000_1000,
        ST_FILL_GO   = 10'b00_0001_0000,
        ST_FILL_WAIT = 10'b00_0010_0000,
        ST_CHECK     = 10'b00_0100_0000,
        ST_WAIT_GO   = 10'b00_1000_0000,
        ST_WAIT_WAIT = 10'b01_0000_0000,
        ST_DONE      = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = ST_FILL_GO;
            end
            ST_FILL_GO:
            begin
                if (sts.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_FILL_WAIT;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_FILL_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.fill_add = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.has_token)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.deficit = 1'b1;
                    state_next  = ST_WAIT_GO;
                end
            end
            ST_WAIT_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_wait  = 1'b1;
                state_next    = ST_WAIT_WAIT;
            end
            ST_WAIT_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.wait_take = 1'b1;
                    state_next    = ST_DONE;
                end
            end
            ST_DONE:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

### rtl/keyed_token_bucket_limiter.sv
// ----------------------------------------------------------------------------
// keyed_token_bucket_limiter
// per-bucket token bucket rate limiter with a shared iterative divider
// ----------------------------------------------------------------------------
// a request (bucket index, timestamp) is taken on start while busy is low.
// one result (allowed, tokens_left, retry_after) follows on rsp, marked by a
// one-cycle done strobe; the receiver cannot stall, the result must be taken.
// the divider runs once for a partial refill and once more for the retry wait
// of a denied request. busy stays high for the whole request and drops in the
// done cycle, so one request is in flight at a time and the next can be taken
// on the edge that takes the result; the divider, one quotient bit per cycle,
// sets the rate whenever a division is needed. after reset the bucket table is
// swept clear, one entry a cycle, with busy high; config writes are taken during
// the sweep. config (capacity, refill period) must be written only while the
// block is idle; the block itself does not enforce this rule.
// ----------------------------------------------------------------------------
module keyed_token_bucket_limiter #(
    parameter int NUM_BUCKETS = ktbl_pkg::DEF_NUM_BUCKETS,
    parameter int FRAC_BITS   = ktbl_pkg::DEF_FRAC_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  ktbl_pkg::lim_req_t         req,
    output logic                       done,
    output ktbl_pkg::lim_rsp_t         rsp,
    input  logic                       cfg_we,
    input  ktbl_pkg::cfg_reg_t         cfg_index,
    input  logic [ktbl_pkg::CFG_W-1:0] cfg_data
);

    import ktbl_pkg::*;

    lim_cmd_t cmd;
    lim_sts_t sts;

    ktbl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    ktbl_dp #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

### rtl/ktbl_chk.sv
// ----------------------------------------------------------------------------
// ktbl_chk
// port checks of the keyed token bucket limiter
// ----------------------------------------------------------------------------
module ktbl_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input ktbl_pkg::lim_rsp_t rsp
);

    // accepted request keeps the block busy until its result
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after request transfer");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_allowed_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.allowed |-> rsp.retry_after == '0)
        else $error("retry wait on a granted request");

    a_denied_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done && !rsp.allowed |-> rsp.tokens_left == '0 && rsp.retry_after != '0)
        else $error("bad fields on a denied request");

endmodule

bind keyed_token_bucket_limiter ktbl_chk u_ktbl_chk (.*);

### sim/keyed_token_bucket_limiter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyed_token_bucket_limiter_tb
// self-checking testbench of the keyed token bucket limiter
// ----------------------------------------------------------------------------
// a directed table covers reset behavior, index and timestamp extremes and backward
// or frozen time. Random phases follow under several capacity and period settings,
// the extremes among them. Each result is checked field by field: typed table rows
// against the table, all others against a fixed-point bucket model in the testbench.
// ----------------------------------------------------------------------------
module keyed_token_bucket_limiter_tb;
    import ktbl_pkg::*;

    localparam int NB       = DEF_NUM_BUCKETS;
    localparam int FB       = DEF_FRAC_BITS;
    localparam int WDOG_MAX = 20000;
    localparam int N_PHASES = 6;

    typedef struct {
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] ts;
        bit                typed;
        lim_rsp_t          rsp;
    } dir_row_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    lim_req_t req;
    logic     done;
    lim_rsp_t rsp;
    logic     cfg_we;
    cfg_reg_t cfg_index;
    logic [CFG_W-1:0] cfg_data;

    bit [15:0]     cap_reg;
    bit [19:0]     period_reg;
    bit            bkt_used [NB];
    bit [63:0]     bkt_tokens [NB];
    bit [47:0]     bkt_last [NB];
    lim_rsp_t      pending_rsp [$];
    int            err_cnt;
    int            xfer_cnt;
    int            rsp_cnt;
    int            denied_cnt;
    int            burst_left;
    int            wdog;
    dir_row_t      dir_tab [10];

    keyed_token_bucket_limiter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic lim_rsp_t bucket_charge(logic [IDX_W-1:0] idx, logic [TIME_W-1:0] ts);
        int        b;
        bit [63:0] cap;
        bit [63:0] per;
        bit [63:0] full;
        bit [63:0] tok;
        bit [63:0] elapsed;
        bit [63:0] deficit;
        lim_rsp_t  r;
        b    = int'(idx) % NB;
        cap  = (cap_reg == 0) ? 64'd1 : 64'(cap_reg);
        per  = (period_reg == 0) ? 64'd1 : 64'(period_reg);
        full = cap << FB;
        if (!bkt_used[b])
        begin
            bkt_used[b]   = 1'b1;
            bkt_tokens[b] = full;
            bkt_last[b]   = ts;
        end
        tok = bkt_tokens[b];
        if (ts > bkt_last[b])
        begin
            elapsed = 64'(ts - bkt_last[b]);
            if (elapsed >= per)
                tok = full;
            else
            begin
                tok = tok + (elapsed * full) / per;
                if (tok > full)
                    tok = full;
            end
            bkt_last[b] = ts;
        end
        if (tok >= (64'd1 << FB))
        begin
            tok           = tok - (64'd1 << FB);
            r.allowed     = 1'b1;
            r.tokens_left = tok[FB +: CAP_W];
            r.retry_after = '0;
        end
        else
        begin
            deficit       = (64'd1 << FB) - tok;
            r.allowed     = 1'b0;
            r.tokens_left = '0;
            r.retry_after = PERIOD_W'((deficit * per + full - 1) / full);
        end
        bkt_tokens[b] = tok;
        return r;
    endfunction

    task automatic write_limits(bit [15:0] cap, bit [19:0] per);
        cfg_we    <= 1'b1;
        cfg_index <= REG_CAPACITY;
        cfg_data  <= {4'($urandom), cap};
        @(posedge clk);
        cap_reg    = cap;
        cfg_index <= REG_PERIOD;
        cfg_data  <= per;
        @(posedge clk);
        period_reg = per;
        cfg_we    <= 1'b0;
    endtask

    task automatic send_req(logic [IDX_W-1:0] idx, logic [TIME_W-1:0] ts,
                            bit typed, lim_rsp_t typed_rsp);
        lim_rsp_t p;
        start            <= 1'b1;
        req.bucket_index <= idx;
        req.timestamp    <= ts;
        do
            @(posedge clk);
        while (busy);
        p = bucket_charge(idx, ts);
        pending_rsp.push_back(typed ? typed_rsp : p);
        xfer_cnt++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(0, 12);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (130) @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        lim_rsp_t e;
        if (done)
        begin
            rsp_cnt++;
            if (!rsp.allowed)
                denied_cnt++;
            if (pending_rsp.size() == 0)
            begin
                $error("unexpected result transfer");
                err_cnt++;
            end
            else
            begin
                e = pending_rsp.pop_front();
                if (rsp.allowed !== e.allowed)
                begin
                    $error("allowed: expected %0d, got %0d", e.allowed, rsp.allowed);
                    err_cnt++;
                end
                if (rsp.tokens_left !== e.tokens_left)
                begin
                    $error("tokens_left: expected %0d, got %0d", e.tokens_left, rsp.tokens_left);
                    err_cnt++;
                end
                if (rsp.retry_after !== e.retry_after)
                begin
                    $error("retry_after: expected %0d, got %0d", e.retry_after, rsp.retry_after);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (done || (start && !busy) || cfg_we)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX)
        begin
            $display("timeout with %0d results outstanding", pending_rsp.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        bit [15:0]   ph_cap [N_PHASES];
        bit [19:0]   ph_per [N_PHASES];
        bit [47:0]   tnow;
        bit [7:0]    idx;
        lim_rsp_t    r;
        int          k;
        int          ph;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        req        <= '0;
        cfg_we     <= 1'b0;
        cfg_index  <= REG_CAPACITY;
        cfg_data   <= '0;
        err_cnt    = 0;
        xfer_cnt   = 0;
        rsp_cnt    = 0;
        denied_cnt = 0;
        burst_left = 0;
        wdog       = 0;
        cap_reg    = 16'd1;
        period_reg = 20'd1;
        for (k = 0; k < NB; k++)
        begin
            bkt_used[k]   = 1'b0;
            bkt_tokens[k] = '0;
            bkt_last[k]   = '0;
        end

        dir_tab[0] = '{8'd0,   48'd0,             1'b1, '{1'b1, 16'd0, 20'd0}};
        dir_tab[1] = '{8'd0,   48'd0,             1'b1, '{1'b0, 16'd0, 20'd1}};
        dir_tab[2] = '{8'd0,   48'd1,             1'b1, '{1'b1, 16'd0, 20'd0}};
        dir_tab[3] = '{8'd255, 48'hFFFFFFFFFFFF,  1'b1, '{1'b1, 16'd0, 20'd0}};
        dir_tab[4] = '{8'd255, 48'd0,             1'b1, '{1'b0, 16'd0, 20'd1}};
        dir_tab[5] = '{8'd255, 48'hFFFFFFFFFFFF,  1'b1, '{1'b0, 16'd0, 20'd1}};
        dir_tab[6] = '{8'h55,  48'h555555555555,  1'b0, '0};
        dir_tab[7] = '{8'hAA,  48'hAAAAAAAAAAAA,  1'b0, '0};
        dir_tab[8] = '{8'h55,  48'hAAAAAAAAAAAA,  1'b0, '0};
        dir_tab[9] = '{8'hAA,  48'h555555555555,  1'b0, '0};

        ph_cap[0] = 16'd0;     ph_per[0] = 20'd0;
        ph_cap[1] = 16'd3;     ph_per[1] = 20'd100;
        ph_cap[2] = 16'hFFFF;  ph_per[2] = 20'hFFFFF;
        ph_cap[3] = 16'd1;     ph_per[3] = 20'hFFFFF;
        ph_cap[4] = 16'(($urandom_range(1, 20)));
        ph_per[4] = 20'($urandom_range(1, 5000));
        ph_cap[5] = 16'd2;     ph_per[5] = 20'd7;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < 10; k++)
            send_req(dir_tab[k].idx, dir_tab[k].ts, dir_tab[k].typed, dir_tab[k].rsp);
        drain();

        for (ph = 0; ph < N_PHASES; ph++)
        begin
            write_limits(ph_cap[ph], ph_per[ph]);
            tnow = 48'({$urandom, $urandom});
            for (k = 0; k < 225; k++)
            begin
                idx = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
                case ($urandom_range(0, 9))
                    0:       tnow = tnow;
                    1:       tnow = tnow - 48'($urandom_range(1, 50));
                    2:       tnow = tnow + 48'($urandom_range(0, 2 * ph_per[ph] + 2));
                    default: tnow = tnow + 48'($urandom_range(0, ph_per[ph] / 8 + 1));
                endcase
                send_req(idx, tnow, 1'b0, r);
            end
            // sender holds off until every result is back before the next setting
            drain();
        end

        $display("%0d requests over %0d limit settings, %0d results, %0d denied",
                 xfer_cnt, N_PHASES + 1, rsp_cnt, denied_cnt);
        if (err_cnt == 0 && pending_rsp.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
